// ===== src/sttu_pkg.sv =====
// ---------------------------------------------------------------------------
// Source text tokenizer package
// Shared widths, token kind codes and beat types for the tokenizer.
// ---------------------------------------------------------------------------
package sttu_pkg;

    localparam int POS_WIDTH  = 32;
    localparam int LEN_WIDTH  = 16;
    localparam int KIND_WIDTH = 5;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef logic [KIND_WIDTH-1:0] kind_t;

    localparam kind_t K_EOF     = 5'd0;
    localparam kind_t K_STRING  = 5'd1;
    localparam kind_t K_IDENT   = 5'd2;
    localparam kind_t K_NUMBER  = 5'd3;
    localparam kind_t K_LPAREN  = 5'd4;
    localparam kind_t K_RPAREN  = 5'd5;
    localparam kind_t K_LBRACE  = 5'd6;
    localparam kind_t K_RBRACE  = 5'd7;
    localparam kind_t K_HASH    = 5'd8;
    localparam kind_t K_AT      = 5'd9;
    localparam kind_t K_PLUS    = 5'd10;
    localparam kind_t K_MINUS   = 5'd11;
    localparam kind_t K_STAR    = 5'd12;
    localparam kind_t K_DIV     = 5'd13;
    localparam kind_t K_LT      = 5'd14;
    localparam kind_t K_LE      = 5'd15;
    localparam kind_t K_GT      = 5'd16;
    localparam kind_t K_GE      = 5'd17;
    localparam kind_t K_NOT     = 5'd18;
    localparam kind_t K_NE      = 5'd19;
    localparam kind_t K_ASSIGN  = 5'd20;
    localparam kind_t K_EQ      = 5'd21;
    localparam kind_t K_COLON   = 5'd22;
    localparam kind_t K_SEMI    = 5'd23;
    localparam kind_t K_INVALID = 5'd24;
    localparam kind_t K_UNTERM  = 5'd25;
    localparam kind_t K_ESCEOF  = 5'd26;

    typedef struct packed {
        kind_t                kind;
        logic [POS_WIDTH-1:0] start;
        logic [LEN_WIDTH-1:0] len;
        logic                 last;
    } token_t;

    typedef struct packed {
        logic [1:0] count;
        token_t     tok0;
        token_t     tok1;
    } scan_res_t;

endpackage

// ===== src/sttu_scan.sv =====
// ---------------------------------------------------------------------------
// Tokenizer scanner
// Holds the scan mode, the byte offset and the pending token, and turns one
// byte into zero, one or two tokens.
// ---------------------------------------------------------------------------
module sttu_scan (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic [7:0]         text_byte,
    output sttu_pkg::scan_res_t res
);
    import sttu_pkg::*;

    localparam int MODE_WIDTH = 4;

    localparam logic [MODE_WIDTH-1:0] M_IDLE    = 4'd0;
    localparam logic [MODE_WIDTH-1:0] M_STR     = 4'd1;
    localparam logic [MODE_WIDTH-1:0] M_ESC     = 4'd2;
    localparam logic [MODE_WIDTH-1:0] M_IDENT   = 4'd3;
    localparam logic [MODE_WIDTH-1:0] M_NUM     = 4'd4;
    localparam logic [MODE_WIDTH-1:0] M_SLASH   = 4'd5;
    localparam logic [MODE_WIDTH-1:0] M_COMMENT = 4'd6;
    localparam logic [MODE_WIDTH-1:0] M_LT      = 4'd7;
    localparam logic [MODE_WIDTH-1:0] M_GT      = 4'd8;
    localparam logic [MODE_WIDTH-1:0] M_BANG    = 4'd9;
    localparam logic [MODE_WIDTH-1:0] M_EQ      = 4'd10;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    typedef struct packed {
        logic [MODE_WIDTH-1:0] mode;
        logic                  open_tok;
        logic                  emit;
        kind_t                 kind;
    } idle_t;

    function automatic logic is_alpha(input logic [7:0] b);
        return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A) || b == CH_UNDER;
    endfunction

    function automatic logic is_decimal(input logic [7:0] b);
        return b >= 8'h30 && b <= 8'h39;
    endfunction

    function automatic idle_t idle_step(input logic [7:0] b);
        idle_t r;
        r      = '0;
        r.mode = M_IDLE;
        r.kind = K_EOF;
        if (b == CH_SPACE || b == CH_LF || b == CH_CR || b == CH_TAB) begin
            r.emit = 1'b0;
        end else if (b == CH_NUL) begin
            r.emit = 1'b1;
        end else if (b == CH_QUOTE) begin
            r.mode = M_STR;   r.open_tok = 1'b1;
        end else if (is_alpha(b)) begin
            r.mode = M_IDENT; r.open_tok = 1'b1;
        end else if (is_decimal(b)) begin
            r.mode = M_NUM;   r.open_tok = 1'b1;
        end else begin
            case (b)
                CH_SLASH:  begin r.mode = M_SLASH; r.open_tok = 1'b1; end
                CH_LT:     begin r.mode = M_LT;    r.open_tok = 1'b1; end
                CH_GT:     begin r.mode = M_GT;    r.open_tok = 1'b1; end
                CH_BANG:   begin r.mode = M_BANG;  r.open_tok = 1'b1; end
                CH_EQUAL:  begin r.mode = M_EQ;    r.open_tok = 1'b1; end
                CH_LPAREN: begin r.emit = 1'b1; r.kind = K_LPAREN; end
                CH_RPAREN: begin r.emit = 1'b1; r.kind = K_RPAREN; end
                CH_LBRACE: begin r.emit = 1'b1; r.kind = K_LBRACE; end
                CH_RBRACE: begin r.emit = 1'b1; r.kind = K_RBRACE; end
                CH_HASH:   begin r.emit = 1'b1; r.kind = K_HASH; end
                CH_AT:     begin r.emit = 1'b1; r.kind = K_AT; end
                CH_PLUS:   begin r.emit = 1'b1; r.kind = K_PLUS; end
                CH_MINUS:  begin r.emit = 1'b1; r.kind = K_MINUS; end
                CH_STAR:   begin r.emit = 1'b1; r.kind = K_STAR; end
                CH_COLON:  begin r.emit = 1'b1; r.kind = K_COLON; end
                CH_SEMI:   begin r.emit = 1'b1; r.kind = K_SEMI; end
                default:   begin r.emit = 1'b1; r.kind = K_INVALID; end
            endcase
        end
        return r;
    endfunction

    logic [MODE_WIDTH-1:0] mode_reg, mode_next;
    logic [POS_WIDTH-1:0]  pos_reg, pos_next;
    logic [POS_WIDTH-1:0]  start_reg, start_next;
    logic [LEN_WIDTH-1:0]  len_reg, len_next;

    logic [LEN_WIDTH-1:0]  grown;
    idle_t                 idl;
    logic                  run_idle;
    logic                  idle_emit;
    logic                  op_v;
    kind_t                 op_kind;
    token_t                pre_tok;
    logic                  pre_v;
    token_t                idle_tok;

    always_comb begin
        grown      = (len_reg == '1) ? len_reg : len_reg + LEN_WIDTH'(1);
        idl        = idle_step(text_byte);
        mode_next  = mode_reg;
        start_next = start_reg;
        len_next   = len_reg;
        run_idle   = 1'b0;
        op_v       = 1'b0;
        op_kind    = K_LT;
        pre_v      = 1'b0;
        pre_tok    = '{kind: K_EOF, start: start_reg, len: len_reg, last: 1'b0};

        unique case (mode_reg)
            M_STR: begin
                if (text_byte == CH_QUOTE) begin
                    len_next     = grown;
                    pre_v        = 1'b1;
                    pre_tok.kind = K_STRING;
                    pre_tok.len  = grown;
                    mode_next    = M_IDLE;
                end else if (text_byte == CH_NUL) begin
                    pre_v        = 1'b1;
                    pre_tok.kind = K_UNTERM;
                    run_idle     = 1'b1;
                end else begin
                    len_next = grown;
                    if (text_byte == CH_BSLASH) begin
                        mode_next = M_ESC;
                    end
                end
            end
            M_ESC: begin
                if (text_byte == CH_NUL) begin
                    pre_v        = 1'b1;
                    pre_tok.kind = K_ESCEOF;
                    run_idle     = 1'b1;
                end else begin
                    len_next  = grown;
                    mode_next = M_STR;
                end
            end
            M_IDENT: begin
                if (is_alpha(text_byte) || is_decimal(text_byte)) begin
                    len_next = grown;
                end else begin
                    pre_v        = 1'b1;
                    pre_tok.kind = K_IDENT;
                    run_idle     = 1'b1;
                end
            end
            M_NUM: begin
                if (is_decimal(text_byte)) begin
                    len_next = grown;
                end else begin
                    pre_v        = 1'b1;
                    pre_tok.kind = K_NUMBER;
                    run_idle     = 1'b1;
                end
            end
            M_SLASH: begin
                if (text_byte == CH_SLASH) begin
                    mode_next = M_COMMENT;
                end else begin
                    pre_v        = 1'b1;
                    pre_tok.kind = K_DIV;
                    pre_tok.len  = LEN_WIDTH'(1);
                    run_idle     = 1'b1;
                end
            end
            M_COMMENT: begin
                if (text_byte == CH_LF) begin
                    mode_next = M_IDLE;
                end else if (text_byte == CH_NUL) begin
                    run_idle = 1'b1;
                end
            end
            M_LT:   begin op_v = 1'b1; op_kind = K_LT; end
            M_GT:   begin op_v = 1'b1; op_kind = K_GT; end
            M_BANG: begin op_v = 1'b1; op_kind = K_NOT; end
            M_EQ:   begin op_v = 1'b1; op_kind = K_ASSIGN; end
            default: begin
                run_idle = 1'b1;
            end
        endcase

        if (op_v) begin
            pre_v = 1'b1;
            if (text_byte == CH_EQUAL) begin
                pre_tok.kind = op_kind + KIND_WIDTH'(1);
                pre_tok.len  = LEN_WIDTH'(2);
                mode_next    = M_IDLE;
            end else begin
                pre_tok.kind = op_kind;
                pre_tok.len  = LEN_WIDTH'(1);
                run_idle     = 1'b1;
            end
        end

        if (run_idle) begin
            mode_next = idl.mode;
            if (idl.open_tok) begin
                start_next = pos_reg;
                len_next   = LEN_WIDTH'(1);
            end
        end

        if (text_byte == CH_NUL) begin
            mode_next  = M_IDLE;
            pos_next   = '0;
            start_next = '0;
            len_next   = '0;
        end else begin
            pos_next = pos_reg + POS_WIDTH'(1);
        end

        idle_emit = run_idle && idl.emit;
        idle_tok  = '{kind: idl.kind, start: pos_reg,
                      len: (idl.kind == K_EOF) ? LEN_WIDTH'(0) : LEN_WIDTH'(1),
                      last: 1'b1};
        pre_tok.last = !idle_emit;

        res.count = {1'b0, pre_v} + {1'b0, idle_emit};
        res.tok0  = pre_v ? pre_tok : idle_tok;
        res.tok1  = idle_tok;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= M_IDLE;
            pos_reg   <= '0;
            start_reg <= '0;
            len_reg   <= '0;
        end else if (en) begin
            mode_reg  <= mode_next;
            pos_reg   <= pos_next;
            start_reg <= start_next;
            len_reg   <= len_next;
        end
    end

endmodule

// ===== src/source_text_tokenizer_unit.sv =====
// ---------------------------------------------------------------------------
// Source text tokenizer
// Streaming lexer: one text byte per input beat, one token per output beat.
// ---------------------------------------------------------------------------
// The block takes one byte per cycle while the four-entry result queue has
// room for two tokens. A byte is registered on acceptance and scanned once
// that room is there; the tokens it completes are written into the queue. A
// byte that both closes a pending token and forms another gives two beats,
// and the result side then moves one beat per cycle while the receiver is
// ready. Byte 0 ends the text: it always yields an end-of-text token, and the
// next byte starts at offset 0.
module source_text_tokenizer_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [7:0]                     s_text_byte,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [sttu_pkg::KIND_WIDTH-1:0] m_token_kind,
    output logic [sttu_pkg::POS_WIDTH-1:0]  m_start_pos,
    output logic [sttu_pkg::LEN_WIDTH-1:0]  m_token_len,
    output logic                           m_last_of_run
);
    import sttu_pkg::*;

    logic                  in_valid_reg;
    logic [7:0]            in_byte_reg;
    logic                  fire;
    logic                  pop;
    scan_res_t             res;

    token_t                fifo_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [FIFO_CNT_W-1:0] count_reg;
    logic [FIFO_CNT_W-1:0] count_next;
    token_t                head;

    assign fire    = in_valid_reg && (count_reg <= FIFO_CNT_W'(FIFO_DEPTH - 2));
    assign s_ready = !in_valid_reg || fire;
    assign m_valid = count_reg != '0;
    assign pop     = m_valid && m_ready;

    assign head          = fifo_reg[rd_ptr_reg];
    assign m_token_kind  = head.kind;
    assign m_start_pos   = head.start;
    assign m_token_len   = head.len;
    assign m_last_of_run = head.last;

    sttu_scan u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (fire),
        .text_byte (in_byte_reg),
        .res       (res)
    );

    always_comb begin
        count_next = count_reg;
        if (fire) begin
            count_next = count_next + FIFO_CNT_W'(res.count);
        end
        if (pop) begin
            count_next = count_next - FIFO_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            rd_ptr_reg   <= '0;
            wr_ptr_reg   <= '0;
            count_reg    <= '0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (fire) begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_PTR_W'(res.count);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + FIFO_PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready) begin
            in_byte_reg <= s_text_byte;
        end
        if (fire && res.count != 2'd0) begin
            fifo_reg[wr_ptr_reg] <= res.tok0;
        end
        if (fire && res.count == 2'd2) begin
            fifo_reg[wr_ptr_reg + FIFO_PTR_W'(1)] <= res.tok1;
        end
    end

endmodule

// ===== src/sttu_checker.sv =====
// ---------------------------------------------------------------------------
// Tokenizer port checker
// Watches the result channel of the tokenizer and flags broken token rules.
// ---------------------------------------------------------------------------
module sttu_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic [sttu_pkg::KIND_WIDTH-1:0] m_token_kind,
    input logic [sttu_pkg::POS_WIDTH-1:0]  m_start_pos,
    input logic [sttu_pkg::LEN_WIDTH-1:0]  m_token_len,
    input logic                            m_last_of_run
);
    import sttu_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_token_kind) && $stable(m_start_pos)
            && $stable(m_token_len) && $stable(m_last_of_run))
        else $error("Result beat changed while stalled.");

    a_eof: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_token_kind == K_EOF |-> m_token_len == '0 && m_last_of_run)
        else $error("End-of-text token has a length or is not last.");

    a_str_err: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_token_kind == K_UNTERM || m_token_kind == K_ESCEOF)
            |-> !m_last_of_run)
        else $error("String error token not followed by end of text.");

    a_two_char: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_token_kind == K_LE || m_token_kind == K_GE || m_token_kind == K_NE
            || m_token_kind == K_EQ) |-> m_token_len == LEN_WIDTH'(2) && m_last_of_run)
        else $error("Two-character operator with wrong length or flag.");

endmodule

bind source_text_tokenizer_unit sttu_checker u_sttu_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_token_kind  (m_token_kind),
    .m_start_pos   (m_start_pos),
    .m_token_len   (m_token_len),
    .m_last_of_run (m_last_of_run)
);

// ===== tb/tb_source_text_tokenizer_unit.sv =====
// ---------------------------------------------------------------------------
// Source text tokenizer testbench
// Streams text bytes into the tokenizer with random gaps on both channels and
// compares every result beat with the tokens predicted for the bytes taken.
// ---------------------------------------------------------------------------
module tb_source_text_tokenizer_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import sttu_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 2000000;
    localparam int TAIL_CYCLES  = 20;
    localparam int RANDOM_ITEMS = 1300;
    localparam int LONG_RUN     = 150;
    localparam int HOLD_CYCLES  = 400;
    localparam int MAX_PRINTS   = 40;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    typedef enum logic [3:0] {
        LX_IDLE, LX_STR, LX_ESC, LX_IDENT, LX_NUM, LX_SLASH,
        LX_COMMENT, LX_LT, LX_GT, LX_BANG, LX_EQ
    } lex_mode_e;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic [7:0]            s_text_byte;
    logic                  m_valid;
    logic                  m_ready;
    logic [KIND_WIDTH-1:0] m_token_kind;
    logic [POS_WIDTH-1:0]  m_start_pos;
    logic [LEN_WIDTH-1:0]  m_token_len;
    logic                  m_last_of_run;

    source_text_tokenizer_unit dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_text_byte   (s_text_byte),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_token_kind  (m_token_kind),
        .m_start_pos   (m_start_pos),
        .m_token_len   (m_token_len),
        .m_last_of_run (m_last_of_run)
    );

    always #CLK_HALF aclk = ~aclk;

    // Lexer state mirrored on the testbench side.
    lex_mode_e            lex_mode  = LX_IDLE;
    logic [POS_WIDTH-1:0] lex_pos   = '0;
    logic [POS_WIDTH-1:0] lex_start = '0;
    logic [LEN_WIDTH-1:0] lex_len   = '0;

    token_t token_q[$];
    token_t byte_toks[$];

    int  error_count = 0;
    int  cycle_count = 0;
    int  sent_bytes  = 0;
    bit  src_idle    = 1'b0;
    bit  sink_idle   = 1'b0;
    int  sink_hold   = 0;

    function automatic bit is_word(input logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
    endfunction

    function automatic bit is_decimal(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic bit is_blank(input logic [7:0] b);
        return b == CH_SPACE || b == CH_NL || b == CH_CR || b == CH_TAB;
    endfunction

    function automatic void add_tok(input kind_t k, input logic [POS_WIDTH-1:0] st,
                                    input logic [LEN_WIDTH-1:0] ln);
        token_t t;
        if (byte_toks.size() >= 2) return;
        t.kind  = k;
        t.start = st;
        t.len   = ln;
        t.last  = 1'b0;
        byte_toks.push_back(t);
    endfunction

    function automatic void open_tok(input lex_mode_e md, input logic [POS_WIDTH-1:0] p);
        lex_mode  = md;
        lex_start = p;
        lex_len   = LEN_WIDTH'(1);
    endfunction

    function automatic void grow_run();
        if (lex_len != '1) lex_len = lex_len + LEN_WIDTH'(1);
    endfunction

    function automatic void from_idle(input logic [7:0] b, input logic [POS_WIDTH-1:0] p);
        kind_t k;
        lex_mode = LX_IDLE;
        if (is_blank(b)) return;
        if (b == CH_NUL) begin
            add_tok(K_EOF, p, '0);
            return;
        end
        if (b == CH_QUOTE) begin
            open_tok(LX_STR, p);
            return;
        end
        if (is_word(b)) begin
            open_tok(LX_IDENT, p);
            return;
        end
        if (is_decimal(b)) begin
            open_tok(LX_NUM, p);
            return;
        end
        case (b)
            CH_SLASH: begin open_tok(LX_SLASH, p); return; end
            "<":      begin open_tok(LX_LT, p);    return; end
            ">":      begin open_tok(LX_GT, p);    return; end
            "!":      begin open_tok(LX_BANG, p);  return; end
            CH_EQ:    begin open_tok(LX_EQ, p);    return; end
            "(":      k = K_LPAREN;
            ")":      k = K_RPAREN;
            "{":      k = K_LBRACE;
            "}":      k = K_RBRACE;
            "#":      k = K_HASH;
            "@":      k = K_AT;
            "+":      k = K_PLUS;
            "-":      k = K_MINUS;
            "*":      k = K_STAR;
            ":":      k = K_COLON;
            ";":      k = K_SEMI;
            default:  k = K_INVALID;
        endcase
        add_tok(k, p, LEN_WIDTH'(1));
    endfunction

    // Works out the tokens that one accepted byte releases and queues them.
    function automatic void lex_byte(input logic [7:0] b);
        logic [POS_WIDTH-1:0] p;
        kind_t                op_short;
        kind_t                op_long;
        bit                   op_pending;
        p          = lex_pos;
        op_pending = 1'b0;
        op_short   = K_EOF;
        op_long    = K_EOF;
        byte_toks.delete();
        case (lex_mode)
            LX_STR: begin
                if (b == CH_QUOTE) begin
                    grow_run();
                    add_tok(K_STRING, lex_start, lex_len);
                    lex_mode = LX_IDLE;
                end else if (b == CH_NUL) begin
                    add_tok(K_UNTERM, lex_start, lex_len);
                    from_idle(b, p);
                end else begin
                    grow_run();
                    if (b == CH_BSLASH) lex_mode = LX_ESC;
                end
            end
            LX_ESC: begin
                if (b == CH_NUL) begin
                    add_tok(K_ESCEOF, lex_start, lex_len);
                    from_idle(b, p);
                end else begin
                    grow_run();
                    lex_mode = LX_STR;
                end
            end
            LX_IDENT: begin
                if (is_word(b) || is_decimal(b)) begin
                    grow_run();
                end else begin
                    add_tok(K_IDENT, lex_start, lex_len);
                    from_idle(b, p);
                end
            end
            LX_NUM: begin
                if (is_decimal(b)) begin
                    grow_run();
                end else begin
                    add_tok(K_NUMBER, lex_start, lex_len);
                    from_idle(b, p);
                end
            end
            LX_SLASH: begin
                if (b == CH_SLASH) begin
                    lex_mode = LX_COMMENT;
                end else begin
                    add_tok(K_DIV, lex_start, LEN_WIDTH'(1));
                    from_idle(b, p);
                end
            end
            LX_COMMENT: begin
                if (b == CH_NL) lex_mode = LX_IDLE;
                else if (b == CH_NUL) from_idle(b, p);
            end
            LX_LT:   begin op_pending = 1'b1; op_short = K_LT;     op_long = K_LE; end
            LX_GT:   begin op_pending = 1'b1; op_short = K_GT;     op_long = K_GE; end
            LX_BANG: begin op_pending = 1'b1; op_short = K_NOT;    op_long = K_NE; end
            LX_EQ:   begin op_pending = 1'b1; op_short = K_ASSIGN; op_long = K_EQ; end
            default: from_idle(b, p);
        endcase
        if (op_pending) begin
            if (b == CH_EQ) begin
                add_tok(op_long, lex_start, LEN_WIDTH'(2));
                lex_mode = LX_IDLE;
            end else begin
                add_tok(op_short, lex_start, LEN_WIDTH'(1));
                from_idle(b, p);
            end
        end
        if (b == CH_NUL) begin
            lex_mode  = LX_IDLE;
            lex_pos   = '0;
            lex_start = '0;
            lex_len   = '0;
        end else begin
            lex_pos = p + POS_WIDTH'(1);
        end
        if (byte_toks.size() > 0) byte_toks[byte_toks.size()-1].last = 1'b1;
        foreach (byte_toks[i]) token_q.push_back(byte_toks[i]);
        sent_bytes++;
    endfunction

    task automatic report(input string what, input logic [31:0] got,
                          input logic [31:0] want_v);
        error_count++;
        if (error_count <= MAX_PRINTS)
            $display("mismatch at cycle %0d: %s got %0d expected %0d",
                     cycle_count, what, got, want_v);
    endtask

    always @(posedge aclk) begin : token_check
        token_t want;
        if (aresetn && m_valid && m_ready) begin
            if (token_q.size() == 0) begin
                report("unexpected token, kind", 32'(m_token_kind), 32'hFFFF_FFFF);
            end else begin
                want = token_q.pop_front();
                if (m_token_kind != want.kind)
                    report("token_kind", 32'(m_token_kind), 32'(want.kind));
                if (m_start_pos != want.start)
                    report("start_pos", 32'(m_start_pos), 32'(want.start));
                if (m_token_len != want.len)
                    report("token_len", 32'(m_token_len), 32'(want.len));
                if (m_last_of_run != want.last)
                    report("last_of_run", 32'(m_last_of_run), 32'(want.last));
            end
        end
    end

    initial begin : cycle_limit
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // Result side: a random wait before each beat while sink_idle is set, and a long hold on request.
    initial begin : result_sink
        int w;
        m_ready = 1'b0;
        @(posedge aclk);
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            if (sink_hold > 0) begin
                m_ready <= 1'b0;
                repeat (sink_hold) @(posedge aclk);
                sink_hold = 0;
            end
            w = sink_idle ? $urandom_range(0, 17) : 0;
            if (w > 0) begin
                m_ready <= 1'b0;
                repeat (w) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = src_idle ? $urandom_range(0, 17) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid     <= 1'b1;
        s_text_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        lex_byte(b);
    endtask

    task automatic send_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++) send_byte(s[i]);
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (token_q.size() != 0);
    endtask

    function automatic logic [7:0] word_char(input bit first);
        int sel;
        sel = $urandom_range(0, first ? 52 : 62);
        if (sel < 26) return 8'("a" + sel);
        if (sel < 52) return 8'("A" + sel - 26);
        if (sel == 52) return "_";
        return 8'("0" + sel - 53);
    endfunction

    function automatic logic [7:0] string_char();
        logic [7:0] c;
        do c = 8'($urandom_range(1, 255)); while (c == CH_QUOTE || c == CH_BSLASH);
        return c;
    endfunction

    task automatic test_single_tokens();
        src_idle  = 1'b1;
        sink_idle = 1'b1;
        send_text("_z9 0123(){}#@+-*/:;");
        send_byte(CH_NUL);
    endtask

    task automatic test_operators();
        send_text("<<=>>=!!===a/b");
        send_byte(CH_TAB);
        send_byte(CH_CR);
        send_byte(CH_NUL);
    endtask

    task automatic test_strings_and_invalid();
        send_text("\"a\\\"b\"//c\n");
        send_byte(8'h80);
        send_byte(8'hFF);
        send_text("?");
        send_byte(CH_NUL);
    endtask

    task automatic test_end_cases();
        send_text("\"ab");
        send_byte(CH_NUL);
        send_text("\"\\");
        send_byte(CH_NUL);
        send_text("//x");
        send_byte(CH_NUL);
        send_text("<");
        send_byte(CH_NUL);
        send_text("id");
        send_byte(CH_NUL);
        send_byte(CH_NUL);
    endtask

    task automatic test_long_tokens();
        src_idle  = 1'b0;
        sink_idle = 1'b0;
        repeat (LONG_RUN) send_byte("a");
        send_byte(CH_SPACE);
        send_byte(CH_QUOTE);
        repeat (LONG_RUN) send_byte("s");
        send_byte(CH_QUOTE);
        send_byte(CH_NUL);
        drain_results();
    endtask

    // The receiver stalls while bytes arrive without gaps, every second one giving two tokens.
    task automatic test_result_backpressure();
        src_idle  = 1'b0;
        sink_idle = 1'b0;
        sink_hold = HOLD_CYCLES;
        repeat (80) send_text("<(");
        send_byte(CH_NUL);
        drain_results();
    endtask

    task automatic rand_text();
        int         ntok;
        int         n;
        int         ending;
        string      punct;
        string      ops;
        logic [7:0] blanks [4];
        punct  = "(){}#@+-*:;";
        ops    = "<>!=";
        blanks = '{CH_SPACE, CH_NL, CH_CR, CH_TAB};
        ntok   = $urandom_range(2, 14);
        for (n = 0; n < ntok; n++) begin
            case ($urandom_range(0, 11))
                0: begin
                    send_byte(word_char(1'b1));
                    repeat ($urandom_range(0, 7)) send_byte(word_char(1'b0));
                end
                1: repeat ($urandom_range(1, 6)) send_byte(8'("0" + $urandom_range(0, 9)));
                2: begin
                    send_byte(CH_QUOTE);
                    repeat ($urandom_range(0, 6)) begin
                        if ($urandom_range(0, 3) == 0) begin
                            send_byte(CH_BSLASH);
                            send_byte(8'($urandom_range(1, 255)));
                        end else begin
                            send_byte(string_char());
                        end
                    end
                    send_byte(CH_QUOTE);
                end
                3: send_byte(punct[$urandom_range(0, 10)]);
                4: begin
                    send_byte(ops[$urandom_range(0, 3)]);
                    if ($urandom_range(0, 1) == 1) send_byte(CH_EQ);
                end
                5: send_byte(CH_SLASH);
                6: begin
                    send_byte(CH_SLASH);
                    send_byte(CH_SLASH);
                    repeat ($urandom_range(0, 8)) send_byte(8'($urandom_range(32, 126)));
                    send_byte(CH_NL);
                end
                7, 8: repeat ($urandom_range(1, 3)) send_byte(blanks[$urandom_range(0, 3)]);
                9: send_byte(8'($urandom_range(1, 255)));
                10: send_byte(8'($urandom_range(0, 255)));
                default: send_byte(CH_SPACE);
            endcase
        end
        ending = $urandom_range(0, 9);
        case (ending)
            0: begin
                send_byte(CH_QUOTE);
                repeat ($urandom_range(0, 3)) send_byte(string_char());
                send_byte(CH_NUL);
            end
            1: begin
                send_byte(CH_QUOTE);
                send_byte(string_char());
                send_byte(CH_BSLASH);
                send_byte(CH_NUL);
            end
            2: begin
                send_byte(CH_SLASH);
                send_byte(CH_SLASH);
                send_byte(string_char());
                send_byte(CH_NUL);
            end
            3: ;
            default: send_byte(CH_NUL);
        endcase
    endtask

    task automatic test_random_texts();
        int goal;
        goal = sent_bytes + RANDOM_ITEMS;
        while (sent_bytes < goal) begin
            src_idle  = $urandom_range(0, 3) != 0;
            sink_idle = $urandom_range(0, 3) != 0;
            rand_text();
            if ($urandom_range(0, 5) == 0) drain_results();
        end
    endtask

    initial begin : stimulus
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_text_byte = 8'h00;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_single_tokens();
        test_operators();
        test_strings_and_invalid();
        test_end_cases();
        test_result_backpressure();
        test_long_tokens();
        test_random_texts();

        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
